### src/ttsg_pkg.sv
// Package for the simple glyph decoder: phase codes, flag bits, status codes.
// Used by the decoder top, ttsg_front and ttsg_back; depends on nothing.
package ttsg_pkg;

    localparam int MaxPointsDef   = 64;
    localparam int MaxContoursDef = 16;
    localparam int HeaderBytes    = 10;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ENDPTS = 3'd1,
        PH_INSLEN = 3'd2,
        PH_INSTR  = 3'd3,
        PH_FLAGS  = 3'd4,
        PH_X      = 3'd5,
        PH_Y      = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    localparam int FL_ON     = 0;
    localparam int FL_XSHORT = 1;
    localparam int FL_YSHORT = 2;
    localparam int FL_REPEAT = 3;
    localparam int FL_XSAME  = 4;
    localparam int FL_YSAME  = 5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_COMPOSITE = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // byte queue entry from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_qent;

endpackage

### src/truetype_simple_glyph_decoder.sv
// Simple glyph decoder: takes one glyph record byte per start pulse (while
// busy is low) and strobes one point per o_point_valid cycle, which the
// receiver must take. The parser takes a coordinate byte and evaluates
// it, then reads the stores for the next point; a point with a repeated
// coordinate is evaluated without a byte, and a repeat count expands its
// flag one copy at a time. A two-entry byte queue in front absorbs the start pulses.
// Depends on ttsg_pkg, ttsg_front, ttsg_back.
module truetype_simple_glyph_decoder #(
    parameter int MaxPoints   = ttsg_pkg::MaxPointsDef,
    parameter int MaxContours = ttsg_pkg::MaxContoursDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         i_data_byte,
    input  logic               i_glyph_start,
    output logic               o_point_valid,
    output logic signed [15:0] o_x_coord,
    output logic signed [15:0] o_y_coord,
    output logic               o_on_curve,
    output logic [3:0]         o_contour_number,
    output logic [5:0]         o_index_in_contour,
    output logic               o_contour_first,
    output logic               o_contour_last,
    output logic [5:0]         o_next_point,
    output logic [5:0]         o_point_number,
    output logic               o_final_point,
    output logic [1:0]         o_status
);
    import ttsg_pkg::*;

    logic  q_valid, q_pop;
    t_qent q_ent;

    // accept bytes
    ttsg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_data_byte(i_data_byte), .i_glyph_start(i_glyph_start),
        .o_busy(busy), .o_valid(q_valid), .o_ent(q_ent), .i_pop(q_pop));

    // parse and emit points
    ttsg_back #(.MaxPoints(MaxPoints), .MaxContours(MaxContours)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_ent(q_ent),
        .o_pop(q_pop), .o_point_valid(o_point_valid),
        .o_x_coord(o_x_coord), .o_y_coord(o_y_coord), .o_on_curve(o_on_curve),
        .o_contour_number(o_contour_number),
        .o_index_in_contour(o_index_in_contour),
        .o_contour_first(o_contour_first), .o_contour_last(o_contour_last),
        .o_next_point(o_next_point), .o_point_number(o_point_number),
        .o_final_point(o_final_point), .o_status(o_status));
endmodule

### src/ttsg_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module ttsg_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write, then register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### src/ttsg_front.sv
// Front part: accepts bytes into a short queue and hands them to the back part.
// Depends on ttsg_pkg.
module ttsg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [7:0]    i_data_byte,
    input  logic          i_glyph_start,
    output logic          o_busy,
    output logic          o_valid,
    output ttsg_pkg::t_qent o_ent,
    input  logic          i_pop
);
    import ttsg_pkg::*;

    t_qent      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_ent   = r_q[r_rp];

    // hold bytes in a two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= '{data: i_data_byte, start: i_glyph_start};
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule

### src/ttsg_back.sv
// Back part: parses the glyph record and emits one point per strobe.
// Depends on ttsg_pkg and ttsg_ram.
module ttsg_back #(
    parameter int MaxPoints   = ttsg_pkg::MaxPointsDef,
    parameter int MaxContours = ttsg_pkg::MaxContoursDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ttsg_pkg::t_qent       i_ent,
    output logic                  o_pop,
    output logic                  o_point_valid,
    output logic signed [15:0]    o_x_coord,
    output logic signed [15:0]    o_y_coord,
    output logic                  o_on_curve,
    output logic [3:0]            o_contour_number,
    output logic [5:0]            o_index_in_contour,
    output logic                  o_contour_first,
    output logic                  o_contour_last,
    output logic [5:0]            o_next_point,
    output logic [5:0]            o_point_number,
    output logic                  o_final_point,
    output logic [1:0]            o_status
);
    import ttsg_pkg::*;

    localparam int PW = $clog2(MaxPoints);
    localparam int CW = (MaxContours > 1) ? $clog2(MaxContours) : 1;
    localparam int PCW = PW + 1;
    localparam int CCW = $clog2(MaxContours + 1);

    // sequencer steps: take a byte, wait for store reads, emit/advance, expand flag repeats
    typedef enum logic [1:0] {
        S_TAKE = 2'd0,
        S_READ = 2'd1,
        S_EVAL = 2'd2,
        S_REP  = 2'd3
    } t_step;

    t_step        r_step, n_step;
    t_phase       r_phase;
    logic [3:0]   r_byte_cnt;
    logic [7:0]   r_hi;
    logic [15:0]  r_hdr;
    logic [CCW-1:0] r_ctot;
    logic [CCW-1:0] r_ccur;
    logic [15:0]  r_iskip;
    logic         r_rep_pend;
    logic [7:0]   r_rep_cnt;
    logic [5:0]   r_rep_flag;
    logic [PCW-1:0] r_pcur;
    logic [PCW-1:0] r_ptot;
    logic [PCW-1:0] r_cstart;
    logic [15:0]  r_acc;
    logic         r_have_byte;
    logic [7:0]   r_byte;
    logic [5:0]   r_last_flag;

    // stores
    logic            ep_we;
    logic [CW-1:0]   ep_waddr, ep_raddr;
    logic [15:0]     ep_wdata, ep_rdata;
    logic            fl_we;
    logic [PW-1:0]   fl_waddr, fl_raddr;
    logic [5:0]      fl_wdata, fl_rdata;
    logic            x_we;
    logic [PW-1:0]   x_waddr, x_raddr;
    logic [15:0]     x_wdata, x_rdata;

    ttsg_ram #(.Width(16), .Depth(MaxContours)) u_ep (
        .i_clk(i_clk), .i_we(ep_we), .i_waddr(ep_waddr), .i_wdata(ep_wdata),
        .i_raddr(ep_raddr), .o_rdata(ep_rdata));
    ttsg_ram #(.Width(6), .Depth(MaxPoints)) u_fl (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_raddr(fl_raddr), .o_rdata(fl_rdata));
    ttsg_ram #(.Width(16), .Depth(MaxPoints)) u_x (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_waddr), .i_wdata(x_wdata),
        .i_raddr(x_raddr), .o_rdata(x_rdata));

    assign fl_raddr = r_pcur[PW-1:0];
    assign x_raddr  = r_pcur[PW-1:0];
    assign ep_raddr = r_ccur[CW-1:0];

    // x/y phase helpers
    logic        in_coord;
    logic        fshort, fsame;
    logic [15:0] sdelta, delta;
    logic        need_byte, coord_done;
    logic [15:0] acc_sum;
    logic        yfin, ylast;

    assign in_coord = (r_phase == PH_X) || (r_phase == PH_Y);
    assign fshort = (r_phase == PH_X) ? fl_rdata[FL_XSHORT] : fl_rdata[FL_YSHORT];
    assign fsame  = (r_phase == PH_X) ? fl_rdata[FL_XSAME]  : fl_rdata[FL_YSAME];
    assign need_byte = fshort || !fsame;
    assign sdelta = fsame ? {8'd0, r_byte} : (16'd0 - {8'd0, r_byte});
    always_comb begin
        if (!need_byte) begin
            delta = 16'd0;
        end else if (fshort) begin
            delta = sdelta;
        end else begin
            delta = {r_hi, r_byte};
        end
    end
    assign coord_done = !need_byte || r_have_byte && (fshort || r_byte_cnt[0]);
    assign acc_sum = r_acc + delta;
    assign yfin  = ({1'b0, r_pcur} + 1'b1) >= {1'b0, r_ptot};
    assign ylast = yfin || ({{(16-PCW){1'b0}}, r_pcur} >= ep_rdata);

    // next step
    always_comb begin
        n_step = r_step;
        unique case (r_step)
            S_TAKE: if (i_valid) n_step = S_READ;
            S_READ: n_step = S_EVAL;
            S_EVAL: n_step = S_TAKE;
            S_REP:  n_step = S_REP;
            default: n_step = S_TAKE;
        endcase
    end

    logic [15:0] word;
    assign word = {r_hi, i_ent.data};

    // sequence all work
    always_ff @(posedge i_clk) begin
        ep_we <= 1'b0;
        fl_we <= 1'b0;
        x_we  <= 1'b0;
        o_point_valid <= 1'b0;
        if (!i_rst_n) begin
            r_step <= S_TAKE;
            r_phase <= PH_HEADER;
            r_byte_cnt <= '0;
            r_hi <= '0;
            r_hdr <= '0;
            r_ctot <= '0;
            r_ccur <= '0;
            r_iskip <= '0;
            r_rep_pend <= 1'b0;
            r_rep_cnt <= '0;
            r_pcur <= '0;
            r_ptot <= '0;
            r_cstart <= '0;
            r_acc <= '0;
            r_have_byte <= 1'b0;
        end else begin
            r_step <= n_step;
            unique case (r_step)
                S_TAKE: begin
                    if (i_valid) begin
                        if (i_ent.start) begin
                            r_byte_cnt <= 4'd1;
                            r_hi <= i_ent.data;
                            r_phase <= PH_HEADER;
                            r_ccur <= '0;
                            r_pcur <= '0;
                            r_acc <= '0;
                            r_have_byte <= 1'b0;
                            r_rep_pend <= 1'b0;
                            r_step <= S_TAKE;
                        end else begin
                            r_byte <= i_ent.data;
                            r_have_byte <= 1'b1;
                            unique case (r_phase)
                                PH_HEADER: begin
                                    if (r_byte_cnt == 4'd0) r_hi <= i_ent.data;
                                    if (r_byte_cnt == 4'd1) r_hdr <= word;
                                    if (r_byte_cnt == 4'(HeaderBytes - 1)) begin
                                        r_byte_cnt <= '0;
                                        r_step <= S_TAKE;
                                        if (r_hdr[15]) begin
                                            r_phase <= PH_DONE;
                                            o_point_valid <= 1'b1;
                                            o_status <= ST_COMPOSITE;
                                        end else if (r_hdr == 16'd0) begin
                                            r_phase <= PH_DONE;
                                            o_point_valid <= 1'b1;
                                            o_status <= ST_OK;
                                        end else if (r_hdr > 16'(MaxContours)) begin
                                            r_phase <= PH_DONE;
                                            o_point_valid <= 1'b1;
                                            o_status <= ST_OVERFLOW;
                                        end else begin
                                            r_ctot <= r_hdr[CCW-1:0];
                                            r_ccur <= '0;
                                            r_phase <= PH_ENDPTS;
                                        end
                                    end else begin
                                        r_byte_cnt <= r_byte_cnt + 4'd1;
                                    end
                                    if (r_byte_cnt == 4'(HeaderBytes - 1) ||
                                        r_hdr[15] || 1'b1) begin
                                        o_x_coord <= '0;
                                        o_y_coord <= '0;
                                        o_on_curve <= 1'b0;
                                        o_contour_number <= '0;
                                        o_index_in_contour <= '0;
                                        o_contour_first <= 1'b0;
                                        o_contour_last <= 1'b0;
                                        o_next_point <= '0;
                                        o_point_number <= '0;
                                        o_final_point <= 1'b1;
                                    end
                                    r_step <= S_TAKE;
                                end
                                PH_ENDPTS: begin
                                    r_step <= S_TAKE;
                                    if (!r_byte_cnt[0]) begin
                                        r_hi <= i_ent.data;
                                        r_byte_cnt <= 4'd1;
                                    end else begin
                                        r_byte_cnt <= '0;
                                        ep_we <= 1'b1;
                                        ep_waddr <= r_ccur[CW-1:0];
                                        ep_wdata <= word;
                                        r_ccur <= r_ccur + 1'b1;
                                        if (r_ccur + 1'b1 >= r_ctot) begin
                                            r_ccur <= '0;
                                            if (word >= 16'(MaxPoints)) begin
                                                r_phase <= PH_DONE;
                                                o_point_valid <= 1'b1;
                                                o_status <= ST_OVERFLOW;
                                                o_x_coord <= '0;
                                                o_y_coord <= '0;
                                                o_on_curve <= 1'b0;
                                                o_contour_number <= '0;
                                                o_index_in_contour <= '0;
                                                o_contour_first <= 1'b0;
                                                o_contour_last <= 1'b0;
                                                o_next_point <= '0;
                                                o_point_number <= '0;
                                                o_final_point <= 1'b1;
                                            end else begin
                                                r_ptot <= word[PCW-1:0] + 1'b1;
                                                r_phase <= PH_INSLEN;
                                            end
                                        end
                                    end
                                end
                                PH_INSLEN: begin
                                    r_step <= S_TAKE;
                                    if (r_byte_cnt == 4'd0) begin
                                        r_hi <= i_ent.data;
                                        r_byte_cnt <= 4'd1;
                                    end else begin
                                        r_byte_cnt <= '0;
                                        r_iskip <= word;
                                        r_pcur <= '0;
                                        r_rep_pend <= 1'b0;
                                        r_phase <= (word != 16'd0) ? PH_INSTR : PH_FLAGS;
                                    end
                                end
                                PH_INSTR: begin
                                    r_step <= S_TAKE;
                                    r_iskip <= r_iskip - 16'd1;
                                    if (r_iskip == 16'd1) r_phase <= PH_FLAGS;
                                end
                                PH_FLAGS: begin
                                    if (r_rep_pend) begin
                                        r_rep_pend <= 1'b0;
                                        r_rep_cnt <= i_ent.data;
                                        r_rep_flag <= r_last_flag;
                                        r_step <= S_REP;
                                    end else begin
                                        fl_we <= 1'b1;
                                        fl_waddr <= r_pcur[PW-1:0];
                                        fl_wdata <= i_ent.data[5:0];
                                        r_last_flag <= i_ent.data[5:0];
                                        r_pcur <= r_pcur + 1'b1;
                                        r_rep_pend <= i_ent.data[FL_REPEAT];
                                        r_step <= S_TAKE;
                                        if (r_pcur + 1'b1 >= r_ptot &&
                                            !i_ent.data[FL_REPEAT]) begin
                                            r_phase <= PH_X;
                                            r_pcur <= '0;
                                            r_acc <= '0;
                                            r_byte_cnt <= '0;
                                            r_have_byte <= 1'b0;
                                            r_step <= S_READ;
                                        end
                                    end
                                end
                                PH_X, PH_Y: begin
                                    // byte arrives; evaluate with stored flag
                                    r_step <= S_EVAL;
                                end
                                default: r_step <= S_TAKE;
                            endcase
                        end
                    end
                end
                S_READ: begin
                    // store reads settle this cycle
                    r_step <= S_EVAL;
                end
                S_EVAL: begin
                    r_step <= S_TAKE;
                    if (in_coord) begin
                        if (!coord_done) begin
                            // first byte of a word delta
                            if (r_have_byte) begin
                                r_hi <= r_byte;
                                r_byte_cnt <= 4'd1;
                                r_have_byte <= 1'b0;
                            end
                        end else begin
                            r_have_byte <= r_have_byte && !need_byte;
                            r_byte_cnt <= '0;
                            r_acc <= acc_sum;
                            r_pcur <= r_pcur + 1'b1;
                            if (r_phase == PH_X) begin
                                x_we <= 1'b1;
                                x_waddr <= r_pcur[PW-1:0];
                                x_wdata <= acc_sum;
                                if (r_pcur + 1'b1 >= r_ptot) begin
                                    r_phase <= PH_Y;
                                    r_pcur <= '0;
                                    r_acc <= '0;
                                    r_ccur <= '0;
                                    r_cstart <= '0;
                                end
                                r_step <= S_READ;
                            end else begin
                                o_point_valid <= 1'b1;
                                o_x_coord <= x_rdata;
                                o_y_coord <= acc_sum;
                                o_on_curve <= fl_rdata[FL_ON];
                                o_contour_number <= 4'(r_ccur);
                                o_index_in_contour <= 6'(r_pcur - r_cstart);
                                o_contour_first <= (r_pcur == r_cstart);
                                o_contour_last <= ylast;
                                o_next_point <= ylast ? 6'(r_cstart) : 6'(r_pcur + 1'b1);
                                o_point_number <= 6'(r_pcur);
                                o_final_point <= yfin;
                                o_status <= ST_OK;
                                if (ylast) begin
                                    r_ccur <= r_ccur + 1'b1;
                                    r_cstart <= r_pcur + 1'b1;
                                end
                                if (yfin) begin
                                    r_phase <= PH_DONE;
                                    r_step <= S_TAKE;
                                end else begin
                                    r_step <= S_READ;
                                end
                            end
                        end
                    end
                end
                S_REP: begin
                    // expand one repeated flag per cycle
                    if (r_rep_cnt != 8'd0 && r_pcur < r_ptot) begin
                        fl_we <= 1'b1;
                        fl_waddr <= r_pcur[PW-1:0];
                        fl_wdata <= r_rep_flag;
                        r_pcur <= r_pcur + 1'b1;
                        r_rep_cnt <= r_rep_cnt - 8'd1;
                    end else begin
                        r_step <= S_TAKE;
                        if (r_pcur >= r_ptot) begin
                            r_phase <= PH_X;
                            r_pcur <= '0;
                            r_acc <= '0;
                            r_byte_cnt <= '0;
                            r_have_byte <= 1'b0;
                            r_step <= S_READ;
                        end
                    end
                end
                default: r_step <= S_TAKE;
            endcase
        end
    end

    // pop a byte only when it is taken
    assign o_pop = (r_step == S_TAKE) && i_valid;
endmodule
